// ===== src/wgm_pkg.sv =====
// ----------------------------------------------------------------------------
// Wildcard glob matcher package
// Shared function codes and wildcard byte values.
// ----------------------------------------------------------------------------
package wgm_pkg;

	localparam int MAX_PATTERN_LEN_DEF = 64;

	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] ANY_BYTE  = 8'h3F;

	typedef enum logic [1:0] {
		FN_APPEND = 2'd0,
		FN_SUBJ   = 2'd1,
		FN_END    = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

endpackage

// ===== src/wildcard_glob_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// Wildcard glob matcher
// Matches streamed subject strings against a stored '*' / '?' pattern by
// tracking every live pattern position in parallel.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// in       in_valid/in_ready    func, ch
// out      out_valid/out_ready  matched, pattern_overflow
//
// One request is taken per cycle; all pattern positions are compared at once.
// An end-of-subject request passes the input register, then sets the registered result.
// The set of live positions is held already closed over stars, so the only
// long path is one carry chain of MAX_PATTERN_LEN + 2 bits.
// Reset empties the pattern. A held result stalls an end-of-subject request in
// the input register, and with it every request behind it.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_unit #(
	parameter int MAX_PATTERN_LEN = wgm_pkg::MAX_PATTERN_LEN_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  wgm_pkg::func_t  func,
	input  logic [7:0]      ch,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            matched,
	output logic            pattern_overflow
);
	import wgm_pkg::*;

	localparam int LW = $clog2(MAX_PATTERN_LEN + 1);
	localparam int IW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
	localparam logic [MAX_PATTERN_LEN:0] START_SET = (MAX_PATTERN_LEN + 1)'(1);

	logic                               v_s1;
	func_t                              func_s1;
	logic [7:0]                         ch_s1;
	logic [MAX_PATTERN_LEN-1:0][7:0]    pat_q;
	logic [LW-1:0]                      len_q;
	logic [MAX_PATTERN_LEN:0]           live_q;
	logic [MAX_PATTERN_LEN:0]           start_q;
	logic                               ovf_q;
	logic                               out_valid_q;
	logic                               matched_q;
	logic                               ovf_out_q;
	logic [MAX_PATTERN_LEN:0]           live_nx;
	logic                               s1_go;
	logic                               room;
	logic                               app_star;

	assign room     = (len_q != LW'(MAX_PATTERN_LEN));
	assign app_star = (ch_s1 == STAR_BYTE);
	assign s1_go    = v_s1 && ((func_s1 != FN_END) || !out_valid_q || out_ready);
	assign in_ready = !v_s1 || s1_go;

	wgm_nfa_step #(
		.MAX_PATTERN_LEN(MAX_PATTERN_LEN),
		.LW(LW)
	) u_step (
		.pat(pat_q),
		.len(len_q),
		.live(live_q),
		.ch(ch_s1),
		.live_next(live_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			len_q       <= '0;
			live_q      <= START_SET;
			start_q     <= START_SET;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			if (s1_go) begin
				case (func_s1)
					FN_APPEND: begin
						if (room) begin
							len_q <= len_q + LW'(1);
							if (app_star) begin
								live_q[len_q + LW'(1)]  <= live_q[len_q];
								start_q[len_q + LW'(1)] <= start_q[len_q];
							end
						end else begin
							ovf_q <= 1'b1;
						end
					end
					FN_SUBJ: begin
						live_q <= live_nx;
					end
					FN_END: begin
						live_q <= start_q;
					end
					FN_CLEAR: begin
						len_q   <= '0;
						ovf_q   <= 1'b0;
						live_q  <= START_SET;
						start_q <= START_SET;
					end
					default: begin
					end
				endcase
			end
			if (s1_go && (func_s1 == FN_END)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			ch_s1   <= ch;
		end
		if (s1_go && (func_s1 == FN_APPEND) && room) begin
			pat_q[len_q[IW-1:0]] <= ch_s1;
		end
		if (s1_go && (func_s1 == FN_END)) begin
			matched_q <= live_q[len_q];
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = ovf_out_q;

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == LW'(MAX_PATTERN_LEN)))
		else $error("overflow flag set with room left in the pattern");

	a_start_live: assert property (@(posedge clk) disable iff (!arst_n)
		start_q[0])
		else $error("position zero missing from the start set");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && (func_s1 == FN_END)) |=> out_valid_q)
		else $error("end-of-subject request gave no result");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && (func_s1 == FN_CLEAR)) |=>
		((len_q == '0) && !ovf_q && (live_q == START_SET)))
		else $error("clear request left pattern state behind");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !s1_go) |=> (v_s1 && $stable(func_s1) && $stable(ch_s1)))
		else $error("stalled request lost from the input register");

endmodule

// ===== src/wgm_nfa_step.sv =====
// ----------------------------------------------------------------------------
// Wildcard matcher position step
// Advances the star-closed set of live pattern positions by one subject byte
// and closes the result over runs of stars with a single carry chain.
// ----------------------------------------------------------------------------
module wgm_nfa_step #(
	parameter int MAX_PATTERN_LEN = wgm_pkg::MAX_PATTERN_LEN_DEF,
	parameter int LW = $clog2(MAX_PATTERN_LEN + 1)
) (
	input  logic [MAX_PATTERN_LEN-1:0][7:0] pat,
	input  logic [LW-1:0]                   len,
	input  logic [MAX_PATTERN_LEN:0]        live,
	input  logic [7:0]                      ch,
	output logic [MAX_PATTERN_LEN:0]        live_next
);
	import wgm_pkg::*;

	logic [MAX_PATTERN_LEN-1:0] star;
	logic [MAX_PATTERN_LEN-1:0] hit;
	logic [MAX_PATTERN_LEN:0]   gen;
	logic [MAX_PATTERN_LEN:0]   prop;
	logic [MAX_PATTERN_LEN+1:0] x_ext;
	logic [MAX_PATTERN_LEN+1:0] y_ext;
	logic [MAX_PATTERN_LEN+1:0] sum;
	logic [MAX_PATTERN_LEN+1:0] carry;

	always_comb begin
		for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
			star[i] = (LW'(i) < len) && (pat[i] == STAR_BYTE);
			hit[i]  = (LW'(i) < len) && (pat[i] != STAR_BYTE)
				&& ((pat[i] == ANY_BYTE) || (pat[i] == ch));
		end
	end

	// A live position reaches its successor through a star run: this is the
	// carry recurrence with generate = new positions, propagate = star before.
	assign gen   = {1'b0, live[MAX_PATTERN_LEN-1:0] & star}
		| {live[MAX_PATTERN_LEN-1:0] & hit, 1'b0};
	assign prop  = {star, 1'b0};
	assign x_ext = {1'b0, gen | prop};
	assign y_ext = {1'b0, gen};
	assign sum   = x_ext + y_ext;
	assign carry = sum ^ x_ext ^ y_ext;
	assign live_next = carry[MAX_PATTERN_LEN+1:1];

endmodule
